/* hdl/rht_pkg.sv */
// ----------------------------------------------------------------------------
// rht_pkg
// Shared types, codes and helper functions of the read-only hash table.
// ----------------------------------------------------------------------------
`default_nettype none

package rht_pkg;

  // Field widths of the channels.
  localparam int WORD_W        = 32;
  localparam int KEY_WORDS_MAX = 4;
  localparam int KIND_W        = 2;
  localparam int KW_W          = 3;
  localparam int HB_CFG_W      = 4;
  localparam int EB_W          = 5;
  localparam int STATUS_W      = 3;
  localparam int ENTRY_W       = 10;
  localparam int TOTAL_W       = 11;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_HASH_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORDS = 2'd1;
  localparam logic [HB_CFG_W-1:0]  HASH_BITS_RST = 4'd10;
  localparam logic [KW_W-1:0]      KEY_WORDS_RST = 3'd1;
  localparam int HASH_BITS_MIN = 4;

  // Hash unit constants.
  localparam logic [WORD_W-1:0] HASH_INIT = 32'hdeadbeef;
  localparam int HSTEP_W  = 3;
  localparam logic [HSTEP_W-1:0] MIX_LAST = 3'd5;
  localparam logic [HSTEP_W-1:0] FIN_LAST = 3'd6;

  // Depth of the command queue between front and back.
  localparam int Q_DEPTH = 2;
  localparam int Q_FILL_W = 2;

  typedef logic [KEY_WORDS_MAX-1:0][WORD_W-1:0] key_t;

  typedef enum logic [KIND_W-1:0] {
    OP_QUEUE = 2'd0,
    OP_FIN   = 2'd1,
    OP_LOOK  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_LOCKED   = 3'd1,
    ST_SIZE     = 3'd2,
    ST_FULL     = 3'd3,
    ST_NO_ITEMS = 3'd4
  } status_t;

  // Classified command handed from front to back.
  typedef struct packed {
    op_t  op;
    logic size_ok;
    key_t key;
  } cmd_t;

  // Effective (clamped) register values.
  typedef struct packed {
    logic [EB_W-1:0] bkt_bits;
    logic [KW_W-1:0] key_words;
  } eff_cfg_t;

  typedef struct packed {
    status_t              status;
    logic                 found;
    logic [ENTRY_W-1:0]   entry_index;
    logic [TOTAL_W-1:0]   item_total;
  } res_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_CLR,
    BK_CNT_RD,
    BK_CNT_HASH,
    BK_CNT_WAIT,
    BK_CNT_UPD,
    BK_SCN_RD,
    BK_SCN_ACC,
    BK_PK_RD,
    BK_PK_START,
    BK_PK_WR,
    BK_LK_WAIT,
    BK_LK_BKT,
    BK_LK_RD,
    BK_LK_CMP
  } bk_state_t;

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x, input int k);
    return (x << k) | (x >> (WORD_W - k));
  endfunction

  // Compares the first words of two keys.
  function automatic logic keys_match(input key_t x, input key_t y,
                                      input logic [KW_W-1:0] words);
    logic eq;
    eq = 1'b1;
    for (int w = 0; w < KEY_WORDS_MAX; w++) begin
      if ((KW_W'(w) < words) && (x[w] != y[w])) eq = 1'b0;
    end
    return eq;
  endfunction

endpackage

`default_nettype wire

/* hdl/rht_ifs.sv */
// ----------------------------------------------------------------------------
// rht channel interfaces
// Valid/ready channels for input items, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface rht_in_if;
  import rht_pkg::*;
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [KW_W-1:0]     key_len_words;
  logic [WORD_W-1:0]   key_word0;
  logic [WORD_W-1:0]   key_word1;
  logic [WORD_W-1:0]   key_word2;
  logic [WORD_W-1:0]   key_word3;
  modport source (output valid, kind, key_len_words, key_word0, key_word1, key_word2,
                  key_word3, input ready);
  modport sink (input valid, kind, key_len_words, key_word0, key_word1, key_word2,
                key_word3, output ready);
endinterface

interface rht_out_if;
  import rht_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                found;
  logic [ENTRY_W-1:0]  entry_index;
  logic [TOTAL_W-1:0]  item_total;
  modport source (output valid, status, found, entry_index, item_total, input ready);
  modport sink (input valid, status, found, entry_index, item_total, output ready);
endinterface

interface rht_cfg_if;
  import rht_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* hdl/read_only_hash_table.sv */
// ----------------------------------------------------------------------------
// read_only_hash_table
// Build-once hash set of 1 to 4 word keys with lookup3 bucket hashing.
// ----------------------------------------------------------------------------
//   channel  dir  content
//   in_ch    in   kind, key_len_words, key_word0..3
//   out_ch   out  status, found, entry_index, item_total
//   cfg_ch   in   index 0 bucket bits, index 1 key_words
//
// A queue or invalid beat is handled in the engine's idle state; a lookup
// hashes the key, fetches its bucket and scans the bucket entries in turn.
// Finalize clears every bucket count, hashes each queued item to take its
// slot, sums start offsets over the buckets in use and packs each item.
// Reset is synchronous; the two-beat front queue takes input up to its depth
// while the engine works or a result waits on a stalled out_ch.
// ----------------------------------------------------------------------------
`default_nettype none

module read_only_hash_table #(
  parameter int HASH_BITS_MAX = 10,
  parameter int MAX_ITEMS     = 1024
) (
  input  wire logic clk,
  input  wire logic rst_n,
  rht_in_if.sink    in_ch,
  rht_out_if.source out_ch,
  rht_cfg_if.sink   cfg_ch
);
  import rht_pkg::*;

  cmd_t     cmd;
  logic     cmd_valid;
  logic     cmd_pop;
  eff_cfg_t eff;

  rht_front #(
    .HASH_BITS_MAX (HASH_BITS_MAX)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_ch    (cfg_ch),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .eff       (eff)
  );

  rht_back #(
    .HASH_BITS_MAX (HASH_BITS_MAX),
    .MAX_ITEMS     (MAX_ITEMS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .eff       (eff),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

/* hdl/rht_front.sv */
// ----------------------------------------------------------------------------
// rht_front
// Register file, item classification and a two-entry command queue.
// ----------------------------------------------------------------------------
`default_nettype none

module rht_front #(
  parameter int HASH_BITS_MAX = 10
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  rht_in_if.sink             in_ch,
  rht_cfg_if.sink            cfg_ch,
  output rht_pkg::cmd_t      cmd,
  output logic               cmd_valid,
  input  wire logic          cmd_pop,
  output rht_pkg::eff_cfg_t  eff
);
  import rht_pkg::*;

  logic [HB_CFG_W-1:0] bkt_bits_r;
  logic [KW_W-1:0]     key_words_r;
  cmd_t                q_r [Q_DEPTH];
  logic                wr_r;
  logic                rd_r;
  logic [Q_FILL_W-1:0] fill_r;
  logic [Q_FILL_W-1:0] fill_nxt;
  logic                push;
  cmd_t                new_cmd;

  // Configuration registers; writes are always taken.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bkt_bits_r  <= HASH_BITS_RST;
      key_words_r <= KEY_WORDS_RST;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == CFG_HASH_BITS) bkt_bits_r <= cfg_ch.data;
      else if (cfg_ch.index == CFG_KEY_WORDS) key_words_r <= cfg_ch.data[KW_W-1:0];
    end
  end

  // Clamp register values to their working ranges.
  always_comb begin
    if (EB_W'(bkt_bits_r) < EB_W'(HASH_BITS_MIN)) eff.bkt_bits = EB_W'(HASH_BITS_MIN);
    else if (EB_W'(bkt_bits_r) > EB_W'(HASH_BITS_MAX)) eff.bkt_bits = EB_W'(HASH_BITS_MAX);
    else eff.bkt_bits = EB_W'(bkt_bits_r);
    if (key_words_r == '0) eff.key_words = KW_W'(1);
    else if (key_words_r > KW_W'(KEY_WORDS_MAX)) eff.key_words = KW_W'(KEY_WORDS_MAX);
    else eff.key_words = key_words_r;
  end

  // Classify the incoming beat.
  always_comb begin
    new_cmd.op      = op_t'(in_ch.kind);
    new_cmd.size_ok = (in_ch.key_len_words == eff.key_words);
    new_cmd.key     = {in_ch.key_word3, in_ch.key_word2, in_ch.key_word1, in_ch.key_word0};
  end

  // Command queue.
  assign in_ch.ready = (fill_r != Q_FILL_W'(Q_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign cmd_valid   = (fill_r != '0);
  assign cmd         = q_r[rd_r];

  always_comb begin
    fill_nxt = fill_r;
    if (push && !cmd_pop) fill_nxt = fill_r + Q_FILL_W'(1);
    else if (!push && cmd_pop) fill_nxt = fill_r - Q_FILL_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r   <= 1'b0;
      rd_r   <= 1'b0;
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
      if (push) wr_r <= ~wr_r;
      if (cmd_pop) rd_r <= ~rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_r] <= new_cmd;
  end

endmodule

`default_nettype wire

/* hdl/rht_hash.sv */
// ----------------------------------------------------------------------------
// rht_hash
// Iterative lookup3 word hash, one mixing sub-step per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rht_hash (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire rht_pkg::key_t                key,
  input  wire logic [rht_pkg::KW_W-1:0]     len,
  output logic                              done,
  output logic [rht_pkg::WORD_W-1:0]        result
);
  import rht_pkg::*;

  logic [WORD_W-1:0]  a_r, b_r, c_r, k3_r;
  logic [WORD_W-1:0]  a_nxt, b_nxt, c_nxt;
  logic [WORD_W-1:0]  init;
  logic [HSTEP_W-1:0] step_r;
  logic               mix_r;
  logic               busy_r;
  logic               done_r;

  assign init   = HASH_INIT + (WORD_W'(len) << 2);
  assign done   = done_r;
  assign result = c_r;

  // One sub-step of the mix or final rounds.
  always_comb begin
    a_nxt = a_r;
    b_nxt = b_r;
    c_nxt = c_r;
    if (mix_r) begin
      unique case (step_r)
        3'd0: begin a_nxt = (a_r - c_r) ^ rotl(c_r, 4);  c_nxt = c_r + b_r; end
        3'd1: begin b_nxt = (b_r - a_r) ^ rotl(a_r, 6);  a_nxt = a_r + c_r; end
        3'd2: begin c_nxt = (c_r - b_r) ^ rotl(b_r, 8);  b_nxt = b_r + a_r; end
        3'd3: begin a_nxt = (a_r - c_r) ^ rotl(c_r, 16); c_nxt = c_r + b_r; end
        3'd4: begin b_nxt = (b_r - a_r) ^ rotl(a_r, 19); a_nxt = a_r + c_r; end
        3'd5: begin
          c_nxt = (c_r - b_r) ^ rotl(b_r, 4);
          b_nxt = b_r + a_r;
          // The tail word joins after the last mix sub-step.
          a_nxt = a_r + k3_r;
        end
        default: ;
      endcase
    end else begin
      unique case (step_r)
        3'd0: c_nxt = (c_r ^ b_r) - rotl(b_r, 14);
        3'd1: a_nxt = (a_r ^ c_r) - rotl(c_r, 11);
        3'd2: b_nxt = (b_r ^ a_r) - rotl(a_r, 25);
        3'd3: c_nxt = (c_r ^ b_r) - rotl(b_r, 16);
        3'd4: a_nxt = (a_r ^ c_r) - rotl(c_r, 4);
        3'd5: b_nxt = (b_r ^ a_r) - rotl(a_r, 14);
        3'd6: c_nxt = (c_r ^ b_r) - rotl(b_r, 24);
        default: ;
      endcase
    end
  end

  // Control of the round sequence.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      mix_r  <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
        mix_r  <= (len == KW_W'(KEY_WORDS_MAX));
      end else if (busy_r) begin
        if (mix_r && step_r == MIX_LAST) begin
          mix_r  <= 1'b0;
          step_r <= '0;
        end else if (!mix_r && step_r == FIN_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          step_r <= step_r + HSTEP_W'(1);
        end
      end
    end
  end

  // Working words.
  always_ff @(posedge clk) begin
    if (start) begin
      k3_r <= key[3];
      a_r  <= init + key[0];
      b_r  <= (len >= KW_W'(2)) ? init + key[1] : init;
      c_r  <= (len >= KW_W'(3)) ? init + key[2] : init;
    end else if (busy_r) begin
      a_r <= a_nxt;
      b_r <= b_nxt;
      c_r <= c_nxt;
    end
  end

endmodule

`default_nettype wire

/* hdl/rht_back.sv */
// ----------------------------------------------------------------------------
// rht_back
// Command engine: pending store, finalize sweeps, bucket search, result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module rht_back #(
  parameter int HASH_BITS_MAX = 10,
  parameter int MAX_ITEMS     = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire rht_pkg::cmd_t      cmd,
  input  wire logic               cmd_valid,
  output logic                    cmd_pop,
  input  wire rht_pkg::eff_cfg_t  eff,
  rht_out_if.source               out_ch
);
  import rht_pkg::*;

  localparam int HB = HASH_BITS_MAX;
  localparam int NB = 1 << HB;
  localparam int IW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW = $clog2(MAX_ITEMS + 1);

  // Memories.
  key_t            pend_mem  [MAX_ITEMS];
  logic [CW-1:0]   slot_mem  [MAX_ITEMS];
  logic [HB-1:0]   hsh_mem   [MAX_ITEMS];
  logic [CW-1:0]   cnt_mem   [NB];
  logic [CW-1:0]   start_mem [NB];
  key_t            pk_mem    [MAX_ITEMS];
  key_t            pend_q, pk_q;
  logic [CW-1:0]   slot_q, cnt_q, start_q;
  logic [HB-1:0]   hsh_q;

  bk_state_t       state_r, state_nxt;
  logic            locked_r, locked_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [IW-1:0]   i_r, i_nxt;
  logic [HB-1:0]   b_r, b_nxt;
  logic [HB-1:0]   bkt_r, bkt_nxt;
  logic [CW-1:0]   total_r, total_nxt;
  logic [CW-1:0]   pos_r, pos_nxt;
  logic [CW-1:0]   rem_r, rem_nxt;
  key_t            key_r, key_nxt;
  logic            out_valid_r, out_valid_nxt;
  res_t            res_r, res_nxt;

  logic            hash_start, hash_done;
  key_t            hash_key;
  logic [WORD_W-1:0] hash_res;
  logic [HB-1:0]   bkt_mask, hbkt, rd_bkt;
  logic            pend_we, tab_we, cnt_we, start_we, pk_we;
  logic [HB-1:0]   cnt_wa;
  logic [CW-1:0]   cnt_wd, pk_wa;
  logic            last_item, emit, fnd;
  status_t         st;
  logic [CW-1:0]   eidx;

  rht_hash u_hash (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (hash_start),
    .key    (hash_key),
    .len    (eff.key_words),
    .done   (hash_done),
    .result (hash_res)
  );

  // Bucket index of the current hash and the shared bucket read address.
  assign bkt_mask  = ~({HB{1'b1}} << eff.bkt_bits);
  assign hbkt      = hash_res[HB-1:0] & bkt_mask;
  assign last_item = ((CW'(i_r) + CW'(1)) == count_r);
  assign pk_wa     = start_q + slot_q;

  always_comb begin
    if (state_r == BK_CNT_WAIT || state_r == BK_LK_WAIT) rd_bkt = hbkt;
    else if (state_r == BK_SCN_RD) rd_bkt = b_r;
    else rd_bkt = hsh_q;
  end

  // Per-item stores, all read at the sweep index.
  always_ff @(posedge clk) begin
    if (pend_we) pend_mem[count_r[IW-1:0]] <= cmd.key;
    pend_q <= pend_mem[i_r];
  end

  always_ff @(posedge clk) begin
    if (tab_we) begin
      slot_mem[i_r] <= cnt_q;
      hsh_mem[i_r]  <= bkt_r;
    end
    slot_q <= slot_mem[i_r];
    hsh_q  <= hsh_mem[i_r];
  end

  // Per-bucket stores.
  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    cnt_q <= cnt_mem[rd_bkt];
  end

  always_ff @(posedge clk) begin
    if (start_we) start_mem[b_r] <= total_r;
    start_q <= start_mem[rd_bkt];
  end

  // Packed key blob.
  always_ff @(posedge clk) begin
    if (pk_we) pk_mem[pk_wa[IW-1:0]] <= pend_q;
    pk_q <= pk_mem[pos_r[IW-1:0]];
  end

  // Sequencer: next state, memory strobes and the result beat.
  always_comb begin
    state_nxt     = state_r;
    locked_nxt    = locked_r;
    count_nxt     = count_r;
    i_nxt         = i_r;
    b_nxt         = b_r;
    bkt_nxt       = bkt_r;
    total_nxt     = total_r;
    pos_nxt       = pos_r;
    rem_nxt       = rem_r;
    key_nxt       = key_r;
    out_valid_nxt = out_valid_r;
    res_nxt       = res_r;
    cmd_pop       = 1'b0;
    hash_start    = 1'b0;
    hash_key      = cmd.key;
    pend_we       = 1'b0;
    tab_we        = 1'b0;
    cnt_we        = 1'b0;
    cnt_wa        = b_r;
    cnt_wd        = '0;
    start_we      = 1'b0;
    pk_we         = 1'b0;
    emit          = 1'b0;
    st            = ST_OK;
    fnd           = 1'b0;
    eidx          = '0;

    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      BK_IDLE: begin
        // A result leaving in this cycle frees the output register.
        if (cmd_valid && (!out_valid_r || out_ch.ready)) begin
          cmd_pop = 1'b1;
          unique case (cmd.op)
            OP_QUEUE: begin
              emit = 1'b1;
              if (locked_r) st = ST_LOCKED;
              else if (!cmd.size_ok) st = ST_SIZE;
              else if (count_r == CW'(MAX_ITEMS)) st = ST_FULL;
              else begin
                pend_we   = 1'b1;
                count_nxt = count_r + CW'(1);
              end
            end
            OP_FIN: begin
              if (locked_r) begin
                emit = 1'b1;
                st   = ST_LOCKED;
              end else if (count_r == '0) begin
                emit = 1'b1;
                st   = ST_NO_ITEMS;
              end else begin
                b_nxt     = '0;
                state_nxt = BK_CLR;
              end
            end
            OP_LOOK: begin
              if (!cmd.size_ok) begin
                emit = 1'b1;
                st   = ST_SIZE;
              end else if (!locked_r) begin
                // Nothing packed yet: every bucket is empty.
                emit = 1'b1;
              end else begin
                key_nxt    = cmd.key;
                hash_start = 1'b1;
                state_nxt  = BK_LK_WAIT;
              end
            end
            OP_NONE: emit = 1'b1;
            default: emit = 1'b1;
          endcase
        end
      end

      // Clear every bucket count.
      BK_CLR: begin
        cnt_we = 1'b1;
        if (b_r == {HB{1'b1}}) begin
          i_nxt     = '0;
          state_nxt = BK_CNT_RD;
        end else begin
          b_nxt = b_r + HB'(1);
        end
      end

      // Hash each pending key and take its slot within the bucket.
      BK_CNT_RD: state_nxt = BK_CNT_HASH;
      BK_CNT_HASH: begin
        hash_start = 1'b1;
        hash_key   = pend_q;
        state_nxt  = BK_CNT_WAIT;
      end
      BK_CNT_WAIT: begin
        if (hash_done) begin
          bkt_nxt   = hbkt;
          state_nxt = BK_CNT_UPD;
        end
      end
      BK_CNT_UPD: begin
        tab_we = 1'b1;
        cnt_we = 1'b1;
        cnt_wa = bkt_r;
        cnt_wd = cnt_q + CW'(1);
        if (last_item) begin
          b_nxt     = '0;
          total_nxt = '0;
          state_nxt = BK_SCN_RD;
        end else begin
          i_nxt     = i_r + IW'(1);
          state_nxt = BK_CNT_RD;
        end
      end

      // Running start offsets over the buckets in use.
      BK_SCN_RD: state_nxt = BK_SCN_ACC;
      BK_SCN_ACC: begin
        start_we  = 1'b1;
        total_nxt = total_r + cnt_q;
        if (b_r == bkt_mask) begin
          i_nxt     = '0;
          state_nxt = BK_PK_RD;
        end else begin
          b_nxt     = b_r + HB'(1);
          state_nxt = BK_SCN_RD;
        end
      end

      // Copy each key to its packed position.
      BK_PK_RD:    state_nxt = BK_PK_START;
      BK_PK_START: state_nxt = BK_PK_WR;
      BK_PK_WR: begin
        pk_we = 1'b1;
        if (last_item) begin
          locked_nxt = 1'b1;
          emit       = 1'b1;
          state_nxt  = BK_IDLE;
        end else begin
          i_nxt     = i_r + IW'(1);
          state_nxt = BK_PK_RD;
        end
      end

      // Lookup: hash, fetch the bucket, scan its entries.
      BK_LK_WAIT: begin
        if (hash_done) state_nxt = BK_LK_BKT;
      end
      BK_LK_BKT: begin
        if (cnt_q == '0) begin
          emit      = 1'b1;
          state_nxt = BK_IDLE;
        end else begin
          pos_nxt   = start_q;
          rem_nxt   = cnt_q;
          state_nxt = BK_LK_RD;
        end
      end
      BK_LK_RD: state_nxt = BK_LK_CMP;
      BK_LK_CMP: begin
        if (keys_match(pk_q, key_r, eff.key_words)) begin
          emit      = 1'b1;
          fnd       = 1'b1;
          eidx      = pos_r;
          state_nxt = BK_IDLE;
        end else if (rem_r == CW'(1)) begin
          emit      = 1'b1;
          state_nxt = BK_IDLE;
        end else begin
          rem_nxt   = rem_r - CW'(1);
          pos_nxt   = pos_r + CW'(1);
          state_nxt = BK_LK_RD;
        end
      end

      default: state_nxt = BK_IDLE;
    endcase

    if (emit) begin
      out_valid_nxt       = 1'b1;
      res_nxt.status      = st;
      res_nxt.found       = fnd;
      res_nxt.entry_index = ENTRY_W'(eidx);
      res_nxt.item_total  = TOTAL_W'(count_nxt);
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      locked_r    <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      locked_r    <= locked_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Sweep indexes and payload.
  always_ff @(posedge clk) begin
    i_r     <= i_nxt;
    b_r     <= b_nxt;
    bkt_r   <= bkt_nxt;
    total_r <= total_nxt;
    pos_r   <= pos_nxt;
    rem_r   <= rem_nxt;
    key_r   <= key_nxt;
    res_r   <= res_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = res_r.status;
  assign out_ch.found       = res_r.found;
  assign out_ch.entry_index = res_r.entry_index;
  assign out_ch.item_total  = res_r.item_total;

endmodule

`default_nettype wire

/* hdl/rht_checker.sv */
// ----------------------------------------------------------------------------
// rht_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rht_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [rht_pkg::STATUS_W-1:0]   status,
  input wire logic                           found,
  input wire logic [rht_pkg::ENTRY_W-1:0]    entry_index,
  input wire logic [rht_pkg::TOTAL_W-1:0]    item_total
);
  import rht_pkg::*;

  logic [TOTAL_W-1:0] last_total_r;

  // Item total of the last delivered beat.
  always_ff @(posedge clk) begin
    if (!rst_n) last_total_r <= '0;
    else if (out_valid && out_ready) last_total_r <= item_total;
  end

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(item_total))
    else $error("result changed while stalled");

  // A hit is only reported with a good status.
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && found |-> status == ST_OK)
    else $error("found with error status");

  // A hit points inside the packed keys.
  a_found_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && found |-> TOTAL_W'(entry_index) < item_total)
    else $error("entry index beyond item total");

  // The key count never goes down.
  a_total_mono: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> item_total >= last_total_r)
    else $error("item total decreased");

endmodule

bind read_only_hash_table rht_checker u_rht_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .status      (out_ch.status),
  .found       (out_ch.found),
  .entry_index (out_ch.entry_index),
  .item_total  (out_ch.item_total)
);

`default_nettype wire

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the read-only hash table. It queues keys under
// several register settings, builds the table, then runs lookups. A
// scoreboard predicts every result from its own copy of the table and
// compares each output beat field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import rht_pkg::*;

  localparam int NUM_SLOTS   = 1024;
  localparam int BUCKETS_MAX = 1024;

  typedef struct {
    status_t     status;
    logic        found;
    logic [9:0]  entry_index;
    logic [10:0] item_total;
  } answer_t;

  // Predicts answers from a private copy of the table and holds them in order.
  class hash_table_scoreboard;
    key_t        pend[NUM_SLOTS];
    int unsigned slot[NUM_SLOTS];
    int unsigned bcnt[BUCKETS_MAX];
    int unsigned bstart[BUCKETS_MAX];
    key_t        blob[NUM_SLOTS];
    int unsigned count;
    bit          locked;
    logic [3:0]  bkt_bits;
    logic [2:0]  key_words;
    answer_t     pending_answers[$];

    function new();
      count = 0;
      locked = 0;
      bkt_bits = HASH_BITS_RST;
      key_words = KEY_WORDS_RST;
      foreach (bcnt[i]) begin
        bcnt[i] = 0;
        bstart[i] = 0;
      end
    endfunction

    function int unsigned bits_eff();
      if (bkt_bits < 4) return 4;
      if (bkt_bits > 10) return 10;
      return 32'(bkt_bits);
    endfunction

    function int unsigned words_eff();
      if (key_words < 1) return 1;
      if (key_words > 4) return 4;
      return 32'(key_words);
    endfunction

    function logic [31:0] rot(logic [31:0] x, int r);
      return (x << r) | (x >> (32 - r));
    endfunction

    // lookup3 word hash with initial value zero.
    function logic [31:0] lookup3(key_t k, int unsigned len);
      logic [31:0] a, b, c;
      int o;
      o = 0;
      a = 32'hdeadbeef + (len << 2);
      b = a;
      c = a;
      while (len > 3) begin
        a += k[o]; b += k[o+1]; c += k[o+2];
        a -= c; a ^= rot(c, 4);  c += b;
        b -= a; b ^= rot(a, 6);  a += c;
        c -= b; c ^= rot(b, 8);  b += a;
        a -= c; a ^= rot(c, 16); c += b;
        b -= a; b ^= rot(a, 19); a += c;
        c -= b; c ^= rot(b, 4);  b += a;
        len -= 3;
        o += 3;
      end
      if (len == 0) return c;
      if (len >= 3) c += k[o+2];
      if (len >= 2) b += k[o+1];
      a += k[o];
      c ^= b; c -= rot(b, 14);
      a ^= c; a -= rot(c, 11);
      b ^= a; b -= rot(a, 25);
      c ^= b; c -= rot(b, 16);
      a ^= c; a -= rot(c, 4);
      b ^= a; b -= rot(a, 14);
      c ^= b; c -= rot(b, 24);
      return c;
    endfunction

    function int unsigned bucket(key_t k);
      return lookup3(k, words_eff()) & ((32'd1 << bits_eff()) - 1);
    endfunction

    function bit same_key(key_t x, key_t y);
      for (int w = 0; w < words_eff(); w++)
        if (x[w] != y[w]) return 0;
      return 1;
    endfunction

    function void write_reg(logic [1:0] idx, logic [3:0] data);
      if (idx == CFG_HASH_BITS) bkt_bits = data;
      else if (idx == CFG_KEY_WORDS) key_words = data[2:0];
    endfunction

    // Updates the table for one accepted input beat and stores its answer.
    function void note_input(op_t kind, logic [2:0] len, key_t k);
      answer_t ans;
      int unsigned h, nb, total, pos;
      ans.status = ST_OK;
      ans.found = 0;
      ans.entry_index = 0;
      case (kind)
        OP_QUEUE: begin
          if (locked) ans.status = ST_LOCKED;
          else if (len != words_eff()) ans.status = ST_SIZE;
          else if (count >= NUM_SLOTS) ans.status = ST_FULL;
          else begin
            pend[count] = k;
            count++;
          end
        end
        OP_FIN: begin
          if (locked) ans.status = ST_LOCKED;
          else if (count == 0) ans.status = ST_NO_ITEMS;
          else begin
            nb = 1 << bits_eff();
            total = 0;
            foreach (bcnt[i]) bcnt[i] = 0;
            for (int i = 0; i < count; i++) begin
              h = bucket(pend[i]);
              slot[i] = bcnt[h];
              bcnt[h]++;
            end
            for (int i = 0; i < nb; i++) begin
              bstart[i] = total;
              total += bcnt[i];
            end
            for (int i = 0; i < count; i++) begin
              pos = bstart[bucket(pend[i])] + slot[i];
              if (pos < NUM_SLOTS) blob[pos] = pend[i];
            end
            locked = 1;
          end
        end
        OP_LOOK: begin
          if (len != words_eff()) ans.status = ST_SIZE;
          else begin
            h = bucket(k);
            for (int u = 0; u < bcnt[h]; u++) begin
              pos = bstart[h] + u;
              if (pos >= NUM_SLOTS) break;
              if (same_key(blob[pos], k)) begin
                ans.found = 1;
                ans.entry_index = 10'(pos);
                break;
              end
            end
          end
        end
        default: ;
      endcase
      ans.item_total = 11'(count);
      pending_answers.push_back(ans);
    endfunction

    // Returns an empty string on a match, else a description of the mismatch.
    function string check_result(logic [2:0] st, logic fnd, logic [9:0] idx,
                                 logic [10:0] tot);
      answer_t e;
      string s;
      if (pending_answers.size() == 0) return "result beat with no answer waiting";
      e = pending_answers.pop_front();
      s = "";
      if (st !== e.status) s = {s, $sformatf(" status %0d/%0d", st, e.status)};
      if (fnd !== e.found) s = {s, $sformatf(" found %0d/%0d", fnd, e.found)};
      if (idx !== e.entry_index)
        s = {s, $sformatf(" entry_index %0d/%0d", idx, e.entry_index)};
      if (tot !== e.item_total)
        s = {s, $sformatf(" item_total %0d/%0d", tot, e.item_total)};
      return s;
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   mismatches;
  bit   quiet;
  bit   hold_req;
  hash_table_scoreboard sb;

  rht_in_if  in_ch();
  rht_out_if out_ch();
  rht_cfg_if cfg_ch();

  read_only_hash_table dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Clock.
  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Run limit.
  initial begin
    #60000000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic report(string s);
    $display("mismatch at %0t:%s", $realtime, s);
    mismatches++;
  endtask

  // Result monitor.
  always @(posedge clk) begin
    string s;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      s = sb.check_result(out_ch.status, out_ch.found, out_ch.entry_index,
                          out_ch.item_total);
      if (s != "") report(s);
    end
  end

  // Receiver: random stall bursts and one long hold-off on request.
  initial begin
    out_ch.ready = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 0;
        repeat (400) @(posedge clk);
        hold_req = 0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        out_ch.ready <= 1;
        @(posedge clk);
      end
    end
  end

  // Sends one input beat and records it once accepted.
  task automatic send(op_t kind, logic [2:0] len, key_t k);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_ch.valid         <= 1;
    in_ch.kind          <= kind;
    in_ch.key_len_words <= len;
    in_ch.key_word0     <= k[0];
    in_ch.key_word1     <= k[1];
    in_ch.key_word2     <= k[2];
    in_ch.key_word3     <= k[3];
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(kind, len, k);
  endtask

  // Stops offering input and waits until every answer has come back.
  task automatic drain();
    in_ch.valid <= 0;
    while (sb.pending_answers.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // One register write; the channel idles after the beat.
  task automatic write_reg(logic [1:0] idx, logic [3:0] data);
    cfg_ch.valid <= 1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 0;
    sb.write_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic reconfigure(logic [3:0] hb, logic [3:0] kw);
    drain();
    write_reg(CFG_HASH_BITS, hb);
    write_reg(CFG_KEY_WORDS, kw);
  endtask

  function automatic key_t rand_key();
    key_t k;
    int r;
    r = $urandom_range(0, 19);
    for (int w = 0; w < 4; w++) k[w] = $urandom();
    if (r == 0) k = '0;
    else if (r == 1) k = '1;
    else if (r < 4 && sb.count > 0) k = sb.pend[$urandom_range(0, sb.count - 1)];
    return k;
  endfunction

  function automatic logic [2:0] bad_len();
    logic [2:0] l;
    do l = 3'($urandom_range(0, 7)); while (l == sb.words_eff());
    return l;
  endfunction

  // Mostly well-formed queue beats, with some noise.
  task automatic queue_phase(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 86) send(OP_QUEUE, 3'(sb.words_eff()), rand_key());
      else if (r < 92) send(OP_QUEUE, bad_len(), rand_key());
      else if (r < 96) send(OP_LOOK, 3'(sb.words_eff()), rand_key());
      else send(OP_NONE, 3'($urandom_range(0, 7)), rand_key());
    end
  endtask

  // Lookups, mostly of stored keys.
  task automatic lookup_phase(int n, bit with_hold);
    int r;
    key_t k;
    for (int i = 0; i < n; i++) begin
      if (with_hold && i == n / 3) hold_req = 1;
      r = $urandom_range(0, 99);
      k = rand_key();
      if (r < 70) k = sb.pend[$urandom_range(0, sb.count - 1)];
      if (r < 88) send(OP_LOOK, 3'(sb.words_eff()), k);
      else if (r < 93) send(OP_LOOK, bad_len(), k);
      else if (r < 96) send(OP_QUEUE, 3'($urandom_range(0, 7)), k);
      else if (r < 98) send(OP_FIN, 3'($urandom_range(0, 7)), k);
      else send(OP_NONE, 3'($urandom_range(0, 7)), k);
    end
  endtask

  // Stimulus.
  initial begin
    key_t ones;
    key_t zeros;
    ones = '1;
    zeros = '0;
    mismatches = 0;
    quiet = 0;
    hold_req = 0;
    sb = new();
    in_ch.valid = 0;
    in_ch.kind = OP_QUEUE;
    in_ch.key_len_words = 0;
    in_ch.key_word0 = 0;
    in_ch.key_word1 = 0;
    in_ch.key_word2 = 0;
    in_ch.key_word3 = 0;
    cfg_ch.valid = 0;
    cfg_ch.index = 0;
    cfg_ch.data = 0;
    rst_n = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Empty table: lookup misses, size errors, finalize with nothing queued.
    send(OP_LOOK, 1, zeros);
    send(OP_LOOK, 2, ones);
    send(OP_FIN, 1, zeros);
    send(OP_NONE, 7, ones);
    send(OP_QUEUE, 3, zeros);
    send(OP_QUEUE, 1, zeros);
    send(OP_QUEUE, 1, ones);
    send(OP_QUEUE, 0, ones);
    send(OP_QUEUE, 7, ones);
    send(OP_LOOK, 1, zeros);
    // Out-of-range registers clamp to the nearest legal value.
    reconfigure(4'd0, 4'd0);
    send(OP_QUEUE, 1, rand_key());
    send(OP_QUEUE, 0, rand_key());
    reconfigure(4'd15, 4'd7);
    send(OP_QUEUE, 4, ones);
    send(OP_QUEUE, 7, ones);
    send(OP_LOOK, 4, ones);
    drain();
    write_reg(2'd2, 4'd15);
    write_reg(2'd3, 4'd0);

    // Fill the store under changing key sizes.
    reconfigure(4'd5, 4'd1);
    queue_phase(250);
    reconfigure(4'd8, 4'd3);
    queue_phase(250);
    reconfigure(4'd10, 4'd4);
    queue_phase(40);
    for (int i = 0; i < 4; i++) send(OP_QUEUE, 4, rand_key());

    // Build the table with few buckets, then try to modify it.
    reconfigure(4'd4, 4'd2);
    send(OP_FIN, 2, zeros);
    send(OP_FIN, 2, zeros);
    send(OP_QUEUE, 2, ones);
    lookup_phase(120, 1);
    reconfigure(4'd10, 4'd4);
    lookup_phase(50, 0);
    reconfigure(4'd15, 4'd0);
    lookup_phase(40, 0);
    reconfigure(4'd4, 4'd2);
    quiet = 1;
    lookup_phase(80, 0);

    drain();
    repeat (200) @(posedge clk);
    if (mismatches == 0 && sb.pending_answers.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
hdl/rht_pkg.sv
hdl/rht_ifs.sv
hdl/rht_front.sv
hdl/rht_hash.sv
hdl/rht_back.sv
hdl/read_only_hash_table.sv
hdl/rht_checker.sv
tb/tb.sv
